// File: rtl/pmst_pkg.sv
// ----------------------------------------------------------------------------
// pmst_pkg
// shared constants for the prim spanning tree engine
// ----------------------------------------------------------------------------
package pmst_pkg;

    localparam int MAX_VERTICES_DEF = 64;
    localparam int WEIGHT_BITS_DEF  = 16;

    localparam int CMD_W     = 2;
    localparam int VID_W     = 6;
    localparam int WEIGHT_W  = 16;
    localparam int COUNT_W   = 7;
    localparam int PARENT_W  = 7;

    localparam logic [CMD_W-1:0] CMD_ADD   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_RUN   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

    localparam logic [COUNT_W-1:0] COUNT_RESET = 7'd64;

endpackage

// File: rtl/prim_minimum_spanning_tree.sv
// ----------------------------------------------------------------------------
// prim_minimum_spanning_tree
// prim spanning tree engine over an adjacency memory
// ----------------------------------------------------------------------------
// usage: a command word is taken when start is high and busy is low.
// add edge: the stored weight is read at the accepting edge, then the two
// mirrored entries are written in turn, keeping the lower weight.
// clear: the store is invalidated by bumping a generation mark
// kept beside each entry (generation memory). when the mark wraps, every 255th
// clear, and after reset, busy stays high for a sweep over all 4096 store
// entries that sets every tag to the unused value 0.
// run: keys, parents and tree flags sit in a vertex memory. an init pass sets
// up every entry, then each round scans the n vertices for the smallest key
// (one memory read a cycle), marks the chosen vertex and relaxes its row.
// there are at most n rounds and a last scan that finds no vertex; then the
// parents of vertices 1 to n-1 are reported, one per cycle on valid, last
// marking the final one.
// the receiver cannot stall: results are not held.
// the config word (vertex_count) is written through cfg_valid/cfg_ready,
// ready whenever the block is idle and start is low.
// ----------------------------------------------------------------------------
module prim_minimum_spanning_tree #(
    parameter int MAX_VERTICES = pmst_pkg::MAX_VERTICES_DEF,
    parameter int WEIGHT_BITS  = pmst_pkg::WEIGHT_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [pmst_pkg::CMD_W-1:0]        command,
    input  logic [pmst_pkg::VID_W-1:0]        end_a,
    input  logic [pmst_pkg::VID_W-1:0]        end_b,
    input  logic [pmst_pkg::WEIGHT_W-1:0]     weight,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [pmst_pkg::COUNT_W-1:0]      cfg_data,
    output logic                              valid,
    output logic [pmst_pkg::VID_W-1:0]        vertex,
    output logic signed [pmst_pkg::PARENT_W-1:0] parent,
    output logic                              last
);
    import pmst_pkg::*;

    localparam int VW    = $clog2(MAX_VERTICES);
    localparam int AW    = 2 * VW;
    localparam int DEPTH = 1 << AW;
    localparam int KW    = WEIGHT_BITS + 1;
    localparam int GW    = 8;
    localparam logic [KW-1:0] KEY_INF = KW'(1) << WEIGHT_BITS;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_ADDR  = 4'd1;
    localparam logic [3:0] S_ADDW  = 4'd2;
    localparam logic [3:0] S_INIT  = 4'd3;
    localparam logic [3:0] S_SCAN  = 4'd4;
    localparam logic [3:0] S_PICK  = 4'd5;
    localparam logic [3:0] S_RELAX = 4'd6;
    localparam logic [3:0] S_OUT   = 4'd7;
    localparam logic [3:0] S_WIPE  = 4'd8;

    // adjacency memory: weight plus generation tag
    logic [WEIGHT_BITS-1:0] adj_w_mem [DEPTH];
    logic [GW-1:0]          adj_g_mem [DEPTH];
    // vertex memory: {in_tree, parent, key}
    localparam int VMW = 1 + PARENT_W + KW;
    logic [VMW-1:0]         vtx_mem [MAX_VERTICES];

    logic [3:0]             state_reg;
    logic [COUNT_W-1:0]     count_reg;
    logic [GW-1:0]          gen_reg;
    logic                   gen_wrap_reg;
    logic [AW-1:0]          wipe_reg;
    logic [VW-1:0]          a_reg, b_reg;
    logic [WEIGHT_BITS-1:0] w_reg;
    logic [COUNT_W-1:0]     n_reg;
    logic [COUNT_W-1:0]     idx_reg;    // issue index
    logic                   rv_reg;     // read data valid
    logic [VW-1:0]          ridx_reg;   // index of read data
    logic [VW-1:0]          u_reg;
    logic                   found_reg;
    logic [KW-1:0]          ukey_reg;
    logic [PARENT_W-1:0]    upar_reg;

    logic [WEIGHT_BITS-1:0] adj_w_q;
    logic [GW-1:0]          adj_g_q;
    logic [VMW-1:0]         vtx_q;

    logic                   adj_we;
    logic [AW-1:0]          adj_wa, adj_ra;
    logic [WEIGHT_BITS-1:0] adj_wd;
    logic [GW-1:0]          adj_gd;
    logic                   vtx_we;
    logic [VW-1:0]          vtx_wa, vtx_ra;
    logic [VMW-1:0]         vtx_wd;

    logic [COUNT_W-1:0]     n_act;
    logic                   q_tree;
    logic [PARENT_W-1:0]    q_par;
    logic [KW-1:0]          q_key;
    logic                   q_present;

    assign n_act = (count_reg < COUNT_W'(2)) ? COUNT_W'(2) :
                   (count_reg > COUNT_W'(MAX_VERTICES)) ? COUNT_W'(MAX_VERTICES) : count_reg;
    assign busy      = (state_reg != S_IDLE) || gen_wrap_reg;
    assign cfg_ready = (state_reg == S_IDLE) && !start;

    assign q_tree    = vtx_q[VMW-1];
    assign q_par     = vtx_q[KW +: PARENT_W];
    assign q_key     = vtx_q[KW-1:0];
    assign q_present = (adj_g_q == gen_reg);

    always_ff @(posedge clk)
    begin
        if (adj_we)
        begin
            adj_w_mem[adj_wa] <= adj_wd;
            adj_g_mem[adj_wa] <= adj_gd;
        end
        adj_w_q <= adj_w_mem[adj_ra];
        adj_g_q <= adj_g_mem[adj_ra];
    end

    always_ff @(posedge clk)
    begin
        if (vtx_we)
        begin
            vtx_mem[vtx_wa] <= vtx_wd;
        end
        vtx_q <= vtx_mem[vtx_ra];
    end

    // memory port control
    always_comb
    begin
        adj_we = 1'b0;
        adj_wa = {a_reg, b_reg};
        adj_wd = w_reg;
        adj_gd = gen_reg;
        adj_ra = {a_reg, b_reg};
        vtx_we = 1'b0;
        vtx_wa = ridx_reg;
        vtx_wd = vtx_q;
        vtx_ra = idx_reg[VW-1:0];
        case (state_reg)
            S_IDLE:
            begin
                adj_ra = {end_a[VW-1:0], end_b[VW-1:0]};
            end
            S_ADDR:
            begin
                if (!(q_present && adj_w_q <= w_reg))
                begin
                    adj_we = 1'b1;
                end
            end
            S_ADDW:
            begin
                adj_wa = {b_reg, a_reg};
                adj_we = 1'b1;
                if (q_present && adj_w_q < w_reg)
                begin
                    adj_wd = adj_w_q;
                end
            end
            S_WIPE:
            begin
                // tag 0 is never a live generation
                adj_we = 1'b1;
                adj_wa = wipe_reg;
                adj_gd = '0;
            end
            S_INIT:
            begin
                vtx_we = 1'b1;
                vtx_wa = idx_reg[VW-1:0];
                vtx_wd = {1'b0, {PARENT_W{1'b1}},
                          (idx_reg == '0) ? KW'(0) : KEY_INF};
            end
            S_PICK:
            begin
                vtx_we = found_reg;
                vtx_wa = u_reg;
                vtx_wd = {1'b1, upar_reg, ukey_reg};
            end
            S_RELAX:
            begin
                adj_ra = {u_reg, idx_reg[VW-1:0]};
                if (rv_reg && !q_tree && q_present &&
                    q_key > {1'b0, adj_w_q})
                begin
                    vtx_we = 1'b1;
                    vtx_wd = {1'b0, PARENT_W'(u_reg), {1'b0, adj_w_q}};
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            count_reg    <= COUNT_RESET;
            gen_reg      <= GW'(1);
            gen_wrap_reg <= 1'b1;
            wipe_reg     <= '0;
            idx_reg      <= '0;
            rv_reg       <= 1'b0;
            found_reg    <= 1'b0;
            valid        <= 1'b0;
            last         <= 1'b0;
        end
        else
        begin
            valid <= 1'b0;
            last  <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (cfg_valid && cfg_ready)
                    begin
                        count_reg <= cfg_data;
                    end
                    if (gen_wrap_reg)
                    begin
                        // entries may carry any tag after power-up or a generation wrap: sweep the store
                        state_reg <= S_WIPE;
                        wipe_reg  <= '0;
                    end
                    else if (start)
                    begin
                        n_reg <= n_act;
                        a_reg <= end_a[VW-1:0];
                        b_reg <= end_b[VW-1:0];
                        w_reg <= WEIGHT_BITS'(weight);
                        case (command)
                            CMD_ADD:
                            begin
                                if (COUNT_W'(end_a) < n_act && COUNT_W'(end_b) < n_act)
                                begin
                                    state_reg <= S_ADDR;
                                end
                            end
                            CMD_RUN:
                            begin
                                state_reg <= S_INIT;
                                idx_reg   <= '0;
                            end
                            CMD_CLEAR:
                            begin
                                gen_reg <= gen_reg + GW'(1);
                                if (gen_reg == {GW{1'b1}})
                                begin
                                    gen_reg      <= GW'(1);
                                    gen_wrap_reg <= 1'b1;
                                end
                            end
                            default:
                            begin
                            end
                        endcase
                    end
                end
                S_WIPE:
                begin
                    wipe_reg <= wipe_reg + AW'(1);
                    if (wipe_reg == AW'(DEPTH - 1))
                    begin
                        gen_wrap_reg <= 1'b0;
                        state_reg    <= S_IDLE;
                    end
                end
                S_ADDR:
                begin
                    state_reg <= S_ADDW;
                end
                S_ADDW:
                begin
                    state_reg <= S_IDLE;
                end
                S_INIT:
                begin
                    idx_reg <= idx_reg + COUNT_W'(1);
                    if (idx_reg == COUNT_W'(MAX_VERTICES - 1))
                    begin
                        idx_reg   <= '0;
                        rv_reg    <= 1'b0;
                        found_reg <= 1'b0;
                        state_reg <= S_SCAN;
                    end
                end
                S_SCAN:
                begin
                    // one vertex read per cycle, compare on the returned word
                    rv_reg   <= (idx_reg < n_reg);
                    ridx_reg <= idx_reg[VW-1:0];
                    if (idx_reg < n_reg)
                    begin
                        idx_reg <= idx_reg + COUNT_W'(1);
                    end
                    if (rv_reg && !q_tree && q_key < KEY_INF &&
                        (!found_reg || q_key < ukey_reg))
                    begin
                        found_reg <= 1'b1;
                        u_reg     <= ridx_reg;
                        ukey_reg  <= q_key;
                        upar_reg  <= q_par;
                    end
                    if (!rv_reg && idx_reg == n_reg)
                    begin
                        state_reg <= S_PICK;
                    end
                end
                S_PICK:
                begin
                    // the chosen word is rewritten from the copy kept by the scan
                    if (found_reg)
                    begin
                        state_reg <= S_RELAX;
                    end
                    else
                    begin
                        state_reg <= S_OUT;
                    end
                    idx_reg <= '0;
                    rv_reg  <= 1'b0;
                end
                S_RELAX:
                begin
                    rv_reg   <= (idx_reg < n_reg);
                    ridx_reg <= idx_reg[VW-1:0];
                    if (idx_reg < n_reg)
                    begin
                        idx_reg <= idx_reg + COUNT_W'(1);
                    end
                    if (!rv_reg && idx_reg == n_reg)
                    begin
                        idx_reg   <= '0;
                        found_reg <= 1'b0;
                        state_reg <= S_SCAN;
                    end
                end
                S_OUT:
                begin
                    rv_reg   <= (idx_reg < n_reg);
                    ridx_reg <= idx_reg[VW-1:0];
                    if (idx_reg < n_reg)
                    begin
                        idx_reg <= idx_reg + COUNT_W'(1);
                    end
                    if (rv_reg && ridx_reg != '0)
                    begin
                        valid  <= 1'b1;
                        vertex <= VID_W'(ridx_reg);
                        parent <= q_par;
                        last   <= (COUNT_W'(ridx_reg) + COUNT_W'(1) == n_reg);
                    end
                    if (!rv_reg && idx_reg == n_reg)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

// File: bench/pmst_check.sv
// ----------------------------------------------------------------------------
// pmst_check
// watches the command, config and result channels of the spanning tree
// engine, keeps its own copy of the graph and predicts each parent word
// ----------------------------------------------------------------------------
module pmst_check
    import pmst_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic                       busy,
    input  logic [CMD_W-1:0]           command,
    input  logic [VID_W-1:0]           end_a,
    input  logic [VID_W-1:0]           end_b,
    input  logic [WEIGHT_W-1:0]        weight,
    input  logic                       cfg_valid,
    input  logic                       cfg_ready,
    input  logic [COUNT_W-1:0]         cfg_data,
    input  logic                       valid,
    input  logic [VID_W-1:0]           vertex,
    input  logic signed [PARENT_W-1:0] parent,
    input  logic                       last,
    output int                         fail_count,
    output int                         pending
);

    localparam int NV      = MAX_VERTICES_DEF;
    localparam int KEY_INF = 1 << WEIGHT_W;

    typedef struct packed {
        logic [VID_W-1:0]           vertex;
        logic signed [PARENT_W-1:0] parent;
        logic                       last;
    } parent_word_t;

    parent_word_t        parent_q[$];
    logic [COUNT_W-1:0]  count_reg;
    logic [WEIGHT_W-1:0] edge_wt [NV*NV];
    bit                  edge_on [NV*NV];

    function automatic int used_count();
        int n;
        n = count_reg;
        if (n < 2) n = 2;
        if (n > NV) n = NV;
        return n;
    endfunction

    function automatic void store_edge(int a, int b, logic [WEIGHT_W-1:0] w);
        int n;
        n = used_count();
        if (a >= n || b >= n) return;
        if (!edge_on[a*NV+b] || w < edge_wt[a*NV+b])
        begin
            edge_wt[a*NV+b] = w;
            edge_wt[b*NV+a] = w;
        end
        edge_on[a*NV+b] = 1'b1;
        edge_on[b*NV+a] = 1'b1;
    endfunction

    // prim from vertex 0, lowest index wins a tie on key
    function automatic void grow_tree();
        int n;
        int u;
        int key [NV];
        int par [NV];
        bit done [NV];
        parent_word_t pw;
        n = used_count();
        for (int v = 0; v < NV; v++)
        begin
            key[v]  = KEY_INF;
            par[v]  = -1;
            done[v] = 1'b0;
        end
        key[0] = 0;
        forever
        begin
            u = n;
            for (int v = 0; v < n; v++)
                if (!done[v] && key[v] < KEY_INF && (u == n || key[v] < key[u]))
                    u = v;
            if (u == n) break;
            done[u] = 1'b1;
            for (int v = 0; v < n; v++)
                if (!done[v] && edge_on[u*NV+v] && key[v] > int'(edge_wt[u*NV+v]))
                begin
                    key[v] = edge_wt[u*NV+v];
                    par[v] = u;
                end
        end
        for (int v = 1; v < n; v++)
        begin
            pw.vertex = v[VID_W-1:0];
            pw.parent = par[v][PARENT_W-1:0];
            pw.last   = (v == n - 1);
            parent_q.insert(parent_q.size(), pw);
        end
    endfunction

    assign pending = parent_q.size();

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg = COUNT_RESET;
            fail_count = 0;
            parent_q.delete();
            for (int i = 0; i < NV*NV; i++)
                edge_on[i] = 1'b0;
        end
        else
        begin
            if (valid)
            begin
                if (parent_q.size() == 0)
                begin
                    $display("%0t: unexpected word vertex %0d parent %0d last %0b",
                             $time, vertex, parent, last);
                    fail_count++;
                end
                else
                begin
                    parent_word_t exp_w;
                    exp_w = parent_q.pop_front();
                    if (vertex !== exp_w.vertex)
                    begin
                        $display("%0t: vertex expected %0d actual %0d",
                                 $time, exp_w.vertex, vertex);
                        fail_count++;
                    end
                    if (parent !== exp_w.parent)
                    begin
                        $display("%0t: parent of %0d expected %0d actual %0d",
                                 $time, exp_w.vertex, exp_w.parent, parent);
                        fail_count++;
                    end
                    if (last !== exp_w.last)
                    begin
                        $display("%0t: last at %0d expected %0b actual %0b",
                                 $time, exp_w.vertex, exp_w.last, last);
                        fail_count++;
                    end
                end
            end
            if (cfg_valid && cfg_ready)
                count_reg = cfg_data;
            if (start && !busy)
            begin
                case (command)
                    CMD_ADD:   store_edge(end_a, end_b, weight);
                    CMD_RUN:   grow_tree();
                    CMD_CLEAR:
                        for (int i = 0; i < NV*NV; i++)
                            edge_on[i] = 1'b0;
                    default: ;
                endcase
            end
        end
    end

endmodule

// File: bench/prim_minimum_spanning_tree_test.sv
// ----------------------------------------------------------------------------
// prim_minimum_spanning_tree_test
// drives edge loads, clears and runs over several vertex counts, directed
// corner cases first and random graphs after; pmst_check does the checking
// ----------------------------------------------------------------------------
module prim_minimum_spanning_tree_test;
    import pmst_pkg::*;

    localparam int CMD_NOP     = 3;
    localparam int CYCLE_LIMIT = 2000000;

    logic                       clk;
    logic                       rst_n;
    logic                       start;
    logic                       busy;
    logic [CMD_W-1:0]           command;
    logic [VID_W-1:0]           end_a;
    logic [VID_W-1:0]           end_b;
    logic [WEIGHT_W-1:0]        weight;
    logic                       cfg_valid;
    logic                       cfg_ready;
    logic [COUNT_W-1:0]         cfg_data;
    logic                       valid;
    logic [VID_W-1:0]           vertex;
    logic signed [PARENT_W-1:0] parent;
    logic                       last;
    int                         fail_count;
    int                         pending;
    int                         cycles;
    int                         gap_pct;
    int                         n_now;

    prim_minimum_spanning_tree i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .command   (command),
        .end_a     (end_a),
        .end_b     (end_b),
        .weight    (weight),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .valid     (valid),
        .vertex    (vertex),
        .parent    (parent),
        .last      (last)
    );

    pmst_check i_check (.*);

    initial clk = 1'b0;
    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    task automatic send_word(int cmd, int a, int b, int w);
        if ($urandom_range(99) < gap_pct)
        begin
            start <= 1'b0;
            repeat ($urandom_range(4, 1)) @(posedge clk);
        end
        start   <= 1'b1;
        command <= cmd[CMD_W-1:0];
        end_a   <= a[VID_W-1:0];
        end_b   <= b[VID_W-1:0];
        weight  <= w[WEIGHT_W-1:0];
        @(posedge clk);
        while (busy) @(posedge clk);
    endtask

    // block idle and drained before the count changes
    task automatic set_count(int v);
        start <= 1'b0;
        @(posedge clk);
        while (pending != 0 || busy) @(posedge clk);
        repeat (8) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= v[COUNT_W-1:0];
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
        n_now = (v < 2) ? 2 : (v > 64) ? 64 : v;
    endtask

    function automatic int pick_weight();
        case ($urandom_range(9))
            0:       return 0;
            1:       return 16'hFFFF;
            2, 3, 4: return $urandom_range(7);
            default: return $urandom_range(16'hFFFF);
        endcase
    endfunction

    // a graph with random content, a few stray words, then a run
    task automatic random_graph(int edges);
        if ($urandom_range(1)) send_word(CMD_CLEAR, 0, 0, 0);
        for (int i = 0; i < edges; i++)
        begin
            case ($urandom_range(19))
                0:       send_word($urandom_range(63) < 32 ? CMD_NOP : CMD_ADD,
                                   $urandom_range(63), $urandom_range(63),
                                   pick_weight());
                1:       send_word(CMD_ADD, $urandom_range(n_now - 1),
                                   $urandom_range(n_now - 1) | 6'h20, pick_weight());
                default: send_word(CMD_ADD, $urandom_range(n_now - 1),
                                   $urandom_range(n_now - 1), pick_weight());
            endcase
        end
        send_word(CMD_RUN, $urandom_range(63), $urandom_range(63),
                  $urandom_range(16'hFFFF));
    endtask

    initial
    begin
        rst_n     = 1'b0;
        start     = 1'b0;
        command   = CMD_ADD;
        end_a     = '0;
        end_b     = '0;
        weight    = '0;
        cfg_valid = 1'b0;
        cfg_data  = '0;
        gap_pct   = 10;
        n_now     = 64;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty graph, repeats, self loop, ties, far vertex, stray words
        send_word(CMD_RUN, 0, 0, 0);
        send_word(CMD_ADD, 0, 1, 16'hFFFF);
        send_word(CMD_ADD, 1, 0, 0);
        send_word(CMD_ADD, 0, 1, 5);
        send_word(CMD_ADD, 1, 1, 0);
        send_word(CMD_ADD, 5, 63, 100);
        send_word(CMD_ADD, 63, 0, 100);
        send_word(CMD_ADD, 1, 5, 100);
        send_word(CMD_ADD, 2, 3, 1);
        send_word(CMD_NOP, 63, 63, 16'hFFFF);
        send_word(CMD_RUN, 63, 63, 16'hFFFF);
        set_count(4);
        send_word(CMD_ADD, 0, 4, 1);
        send_word(CMD_ADD, 63, 1, 1);
        send_word(CMD_ADD, 0, 2, 7);
        send_word(CMD_RUN, 0, 0, 0);
        send_word(CMD_CLEAR, 0, 0, 0);
        send_word(CMD_RUN, 0, 0, 0);
        set_count(0);
        send_word(CMD_ADD, 1, 0, 16'hFFFF);
        send_word(CMD_RUN, 0, 0, 0);
        set_count(127);
        send_word(CMD_ADD, 62, 63, 3);
        send_word(CMD_ADD, 0, 62, 3);
        send_word(CMD_RUN, 0, 0, 0);

        // random graphs over a spread of counts, one phase with no gaps
        set_count(2);
        random_graph(3);
        set_count(5);
        random_graph(8);
        random_graph(6);
        gap_pct = 0;
        set_count(8);
        random_graph(14);
        random_graph(10);
        gap_pct = 10;
        set_count(1);
        random_graph(3);
        set_count(12);
        random_graph(16);
        set_count(100);
        random_graph(20);
        set_count(7);
        random_graph(12);

        start <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (20) @(posedge clk);
        if (fail_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
